>>> src/kpsd_pkg.sv
// Package for the keypad scan, debounce and display core.
// Holds the result type, configuration register indexes, reset values and the segment table.
// Used by kpsd_ctrl, keypad_scan_debounce_display_core and the testbench; depends on nothing.
`default_nettype none

package kpsd_pkg;

    localparam int unsigned SCAN_BITS = 4;
    localparam int unsigned ROW_BITS  = 2;
    localparam int unsigned COL_BITS  = SCAN_BITS - ROW_BITS;
    localparam int unsigned COLUMNS   = 1 << COL_BITS;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_ROUNDS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_TICKS   = 2'd1;

    localparam logic [3:0] DEBOUNCE_ROUNDS_RESET = 4'd2;
    localparam logic [7:0] RELEASE_TICKS_RESET   = 8'd32;

    typedef struct packed {
        logic [COLUMNS-1:0]   column_strobe;
        logic [7:0]           segments;
        logic                 buzzer_level;
        logic                 key_pressed;
        logic [SCAN_BITS-1:0] key_id;
        logic                 key_released;
    } t_result;

    function automatic logic [7:0] seg_pattern(input logic [3:0] code);
        logic [7:0] pattern;
        case (code)
            4'h0: pattern = 8'hfc;
            4'h1: pattern = 8'h60;
            4'h2: pattern = 8'hda;
            4'h3: pattern = 8'hf2;
            4'h4: pattern = 8'h66;
            4'h5: pattern = 8'hb6;
            4'h6: pattern = 8'hbe;
            4'h7: pattern = 8'he0;
            4'h8: pattern = 8'hfe;
            4'h9: pattern = 8'hf6;
            4'ha: pattern = 8'hee;
            4'hb: pattern = 8'h3e;
            4'hc: pattern = 8'h9c;
            4'hd: pattern = 8'h7a;
            4'he: pattern = 8'h9e;
            4'hf: pattern = 8'h8e;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

>>> src/keypad_scan_debounce_display_core.sv
// Top level of the 4x4 keypad scanner with debounce, hex display and buzzer.
// Holds the configuration registers and the output register; instantiates kpsd_ctrl.
// Depends on kpsd_pkg and kpsd_ctrl.
//
//   Channel  Handshake                  Payload
//   in       i_in_valid / o_in_stall    i_return_lines
//   out      o_out_valid / i_out_stall  column strobe, segments, buzzer, key events, key code
//   cfg      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each tick is one transaction; its result is captured in the output register when the tick is accepted.
// A new transaction is accepted every cycle unless the input stalls; the output register is the only stage.
// The input stalls only while a result is held and the output is stalled.
// Synchronous active-low reset restores the configuration defaults and the idle key state.
`default_nettype none

module keypad_scan_debounce_display_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [3:0]                            i_return_lines,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [3:0]                                 o_column_strobe,
    output logic [7:0]                                 o_segments,
    output logic                                       o_buzzer_level,
    output logic                                       o_key_pressed,
    output logic [3:0]                                 o_key_id,
    output logic                                       o_key_released,
    input  wire logic                                  i_cfg_we,
    input  wire logic [kpsd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [kpsd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [3:0]         r_debounce_rounds;
    logic [7:0]         r_release_ticks;
    logic               r_out_valid;
    kpsd_pkg::t_result  r_result;
    kpsd_pkg::t_result  result;
    logic               accept;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    kpsd_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (accept),
        .i_return_lines    (i_return_lines),
        .i_debounce_rounds (r_debounce_rounds),
        .i_release_ticks   (r_release_ticks),
        .o_result          (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_rounds <= kpsd_pkg::DEBOUNCE_ROUNDS_RESET;
            r_release_ticks   <= kpsd_pkg::RELEASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kpsd_pkg::CFG_DEBOUNCE_ROUNDS: r_debounce_rounds <= i_cfg_data[3:0];
                kpsd_pkg::CFG_RELEASE_TICKS:   r_release_ticks   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column_strobe = r_result.column_strobe;
    assign o_segments      = r_result.segments;
    assign o_buzzer_level  = r_result.buzzer_level;
    assign o_key_pressed   = r_result.key_pressed;
    assign o_key_id        = r_result.key_id;
    assign o_key_released  = r_result.key_released;

`ifndef NO_ASSERTIONS
    a_no_press_and_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_key_pressed && o_key_released))
        else $error("press and release reported in the same transaction");

    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(~o_column_strobe))
        else $error("column strobe does not select exactly one column");

    a_blank_columns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_column_strobe[0]) |-> (o_segments == 8'h00))
        else $error("segments driven outside column 0");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");
`endif

endmodule

`default_nettype wire

>>> src/kpsd_ctrl.sv
// Scan, debounce and release control of the keypad core.
// Keeps the scan position and key state and forms one result per accepted tick.
// Depends on kpsd_pkg.
`default_nettype none

module kpsd_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_advance,
    input  wire logic [3:0]                     i_return_lines,
    input  wire logic [3:0]                     i_debounce_rounds,
    input  wire logic [7:0]                     i_release_ticks,
    output kpsd_pkg::t_result                   o_result
);

    logic [kpsd_pkg::SCAN_BITS-1:0] r_pos, n_pos;
    logic                           r_db_active, n_db_active;
    logic [7:0]                     r_db_count, n_db_count;
    logic                           r_held, n_held;
    logic [kpsd_pkg::SCAN_BITS-1:0] r_held_code, n_held_code;
    logic [7:0]                     r_rel_count, n_rel_count;
    logic                           r_buz_en, n_buz_en;
    logic                           r_buz, n_buz;
    logic [kpsd_pkg::SCAN_BITS-1:0] r_shown, n_shown;

    logic [kpsd_pkg::COL_BITS-1:0]  col;
    logic [kpsd_pkg::ROW_BITS-1:0]  row;
    logic                           low;
    logic [3:0]                     rounds;
    logic [7:0]                     db_dec;
    logic                           pressed, released;

    assign col    = r_pos[kpsd_pkg::SCAN_BITS-1:kpsd_pkg::ROW_BITS];
    assign row    = r_pos[kpsd_pkg::ROW_BITS-1:0];
    assign low    = ~i_return_lines[row];
    assign rounds = (i_debounce_rounds == 4'd0) ? 4'd1 : i_debounce_rounds;
    assign db_dec = r_db_count - 8'd1;

    always_comb begin
        n_pos       = r_pos + 1'b1;
        n_db_active = r_db_active;
        n_db_count  = r_db_count;
        n_held      = r_held;
        n_held_code = r_held_code;
        n_rel_count = r_rel_count;
        n_buz_en    = r_buz_en;
        n_buz       = r_buz ^ r_buz_en;
        n_shown     = r_shown;
        pressed     = 1'b0;
        released    = 1'b0;
        if (!r_held) begin
            if (!r_db_active) begin
                if (low) begin
                    n_db_active = 1'b1;
                    n_db_count  = {rounds, {kpsd_pkg::SCAN_BITS{1'b0}}};
                    n_held_code = r_pos;
                end
            end else begin
                n_db_count = db_dec;
                if (db_dec == 8'd0) begin
                    n_db_active = 1'b0;
                    if (low) begin
                        n_held   = 1'b1;
                        n_buz_en = 1'b1;
                        n_shown  = r_held_code;
                        pressed  = 1'b1;
                    end
                end
            end
        end else begin
            if (low) begin
                n_rel_count = i_release_ticks;
            end else if (r_rel_count <= 8'd1) begin
                released    = 1'b1;
                n_buz_en    = 1'b0;
                n_held      = 1'b0;
                n_rel_count = i_release_ticks;
            end else begin
                n_rel_count = r_rel_count - 8'd1;
            end
        end
    end

    always_comb begin
        o_result.column_strobe = ~(kpsd_pkg::COLUMNS'(1) << col);
        o_result.segments      = (col == '0) ? kpsd_pkg::seg_pattern(r_shown) : 8'h00;
        o_result.buzzer_level  = n_buz;
        o_result.key_pressed   = pressed;
        o_result.key_id        = n_held_code;
        o_result.key_released  = released;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_db_active <= 1'b0;
            r_db_count  <= '0;
            r_held      <= 1'b0;
            r_held_code <= '0;
            r_rel_count <= kpsd_pkg::RELEASE_TICKS_RESET;
            r_buz_en    <= 1'b0;
            r_buz       <= 1'b0;
            r_shown     <= '0;
        end else if (i_advance) begin
            r_pos       <= n_pos;
            r_db_active <= n_db_active;
            r_db_count  <= n_db_count;
            r_held      <= n_held;
            r_held_code <= n_held_code;
            r_rel_count <= n_rel_count;
            r_buz_en    <= n_buz_en;
            r_buz       <= n_buz;
            r_shown     <= n_shown;
        end
    end

endmodule

`default_nettype wire

>>> tb/kpsd_tick_checker.sv
// Checker for the keypad scan, debounce and display core: watches the input, output and
// configuration ports, predicts every result and compares it field by field.
// Depends on kpsd_pkg for the result type and the register indexes.
module kpsd_tick_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic [3:0]                          i_return_lines,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic [3:0]                          i_column_strobe,
    input  wire logic [7:0]                          i_segments,
    input  wire logic                                i_buzzer_level,
    input  wire logic                                i_key_pressed,
    input  wire logic [3:0]                          i_key_id,
    input  wire logic                                i_key_released,
    input  wire logic                                i_cfg_we,
    input  wire logic [kpsd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [kpsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] DIGIT_GLYPH [16] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
        8'hfe, 8'hf6, 8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e
    };

    logic [3:0] cfg_rounds;
    logic [7:0] cfg_release;

    logic [3:0] scan_pos;
    logic       settling;
    logic [7:0] settle_left;
    logic       holding;
    logic [3:0] latched_code;
    logic [7:0] release_left;
    logic       buzz_on;
    logic       buzz_pin;
    logic [3:0] display_code;

    kpsd_pkg::t_result expected_ticks[$];
    int                fails = 0;

    function automatic int field_differs(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic predict_tick(input logic [3:0] lines, output kpsd_pkg::t_result r);
        logic [1:0] col;
        logic       row_low;
        col = scan_pos[3:2];
        row_low = !lines[scan_pos[1:0]];
        r = '0;
        r.column_strobe = ~(4'b0001 << col);
        r.segments = (col == 2'd0) ? DIGIT_GLYPH[display_code] : 8'h00;
        if (buzz_on) begin
            buzz_pin = ~buzz_pin;
        end
        if (!holding) begin
            if (!settling) begin
                if (row_low) begin
                    settling = 1'b1;
                    settle_left = {(cfg_rounds == 4'd0) ? 4'd1 : cfg_rounds, 4'b0000};
                    latched_code = scan_pos;
                end
            end else begin
                settle_left = settle_left - 8'd1;
                if (settle_left == 8'd0) begin
                    settling = 1'b0;
                    if (row_low) begin
                        holding = 1'b1;
                        buzz_on = 1'b1;
                        display_code = latched_code;
                        r.key_pressed = 1'b1;
                    end
                end
            end
        end else begin
            if (row_low) begin
                release_left = cfg_release;
            end else if (release_left <= 8'd1) begin
                r.key_released = 1'b1;
                buzz_on = 1'b0;
                holding = 1'b0;
                release_left = cfg_release;
            end else begin
                release_left = release_left - 8'd1;
            end
        end
        scan_pos = scan_pos + 4'd1;
        r.buzzer_level = buzz_pin;
        r.key_id = latched_code;
    endtask

    always @(posedge i_clk) begin
        kpsd_pkg::t_result want;
        if (!i_rst_n) begin
            cfg_rounds = kpsd_pkg::DEBOUNCE_ROUNDS_RESET;
            cfg_release = kpsd_pkg::RELEASE_TICKS_RESET;
            scan_pos = 4'd0;
            settling = 1'b0;
            settle_left = 8'd0;
            holding = 1'b0;
            latched_code = 4'd0;
            release_left = kpsd_pkg::RELEASE_TICKS_RESET;
            buzz_on = 1'b0;
            buzz_pin = 1'b0;
            display_code = 4'd0;
            expected_ticks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    $error("Result transaction arrived with no tick outstanding.");
                    fails++;
                end else begin
                    want = expected_ticks.pop_front();
                    fails += field_differs("column_strobe", want.column_strobe, i_column_strobe)
                           + field_differs("segments", want.segments, i_segments)
                           + field_differs("buzzer_level", want.buzzer_level, i_buzzer_level)
                           + field_differs("key_pressed", want.key_pressed, i_key_pressed)
                           + field_differs("key_id", want.key_id, i_key_id)
                           + field_differs("key_released", want.key_released, i_key_released);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_tick(i_return_lines, want);
                expected_ticks.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kpsd_pkg::CFG_DEBOUNCE_ROUNDS: cfg_rounds = i_cfg_data[3:0];
                    kpsd_pkg::CFG_RELEASE_TICKS:   cfg_release = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_ticks.size();
    end

endmodule

>>> tb/tb_keypad_scan_debounce_display_core.sv
// Top of the testbench for keypad_scan_debounce_display_core: generates key presses, bounce,
// noise and register settings, and gives the verdict from the checker's failure and pending counts.
// Depends on kpsd_pkg, kpsd_tick_checker and the core itself.
module tb_keypad_scan_debounce_display_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [kpsd_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [kpsd_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;
    localparam int CYCLE_LIMIT = 250000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [3:0]                          i_return_lines;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic [3:0]                          o_column_strobe;
    logic [7:0]                          o_segments;
    logic                                o_buzzer_level;
    logic                                o_key_pressed;
    logic [3:0]                          o_key_id;
    logic                                o_key_released;
    logic                                i_cfg_we;
    logic [kpsd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [kpsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int ticks_sent = 0;
    int phase_left = 0;
    int cur_rounds = 2;
    int cur_release = 32;
    bit in_idle_on = 1'b0;
    bit out_idle_on = 1'b0;

    keypad_scan_debounce_display_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_return_lines  (i_return_lines),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_column_strobe (o_column_strobe),
        .o_segments      (o_segments),
        .o_buzzer_level  (o_buzzer_level),
        .o_key_pressed   (o_key_pressed),
        .o_key_id        (o_key_id),
        .o_key_released  (o_key_released),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    kpsd_tick_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_return_lines  (i_return_lines),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_column_strobe (o_column_strobe),
        .i_segments      (o_segments),
        .i_buzzer_level  (o_buzzer_level),
        .i_key_pressed   (o_key_pressed),
        .i_key_id        (o_key_id),
        .i_key_released  (o_key_released),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // While out_idle_on is set, the result side stalls for a fresh random hold-off before each transaction.
    initial begin
        int hold_off;
        forever begin
            hold_off = out_idle_on ? $urandom_range(0, 9) : 0;
            if (hold_off > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    function automatic logic [3:0] key_lines(input logic [3:0] key);
        logic [3:0] lines;
        lines = 4'hf;
        if ((ticks_sent % 16) / 4 == key[3:2]) begin
            lines[key[1:0]] = 1'b0;
        end
        return lines;
    endfunction

    task automatic send_tick(input logic [3:0] lines);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_return_lines <= lines;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent++;
    endtask

    task automatic emit(input logic [3:0] lines);
        if (phase_left > 0) begin
            send_tick(lines);
            phase_left--;
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kpsd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [kpsd_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [3:0] rounds, input logic [7:0] release_v);
        wait_idle();
        write_reg(kpsd_pkg::CFG_DEBOUNCE_ROUNDS, {4'($urandom_range(0, 15)), rounds});
        write_reg(kpsd_pkg::CFG_RELEASE_TICKS, release_v);
        write_reg(CFG_SPARE_LOW, 8'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_HIGH, 8'($urandom_range(0, 255)));
        i_cfg_we <= 1'b0;
        cur_rounds = (rounds == 4'd0) ? 1 : rounds;
        cur_release = (release_v == 8'd0) ? 1 : release_v;
    endtask

    // Mostly complete press, hold and release sequences with bounce, plus noise and
    // presses too short to be confirmed.
    task automatic run_ticks(input int n);
        int choice;
        int hold;
        logic [3:0] key;
        phase_left = n;
        while (phase_left > 0) begin
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            choice = $urandom_range(0, 9);
            key = 4'($urandom_range(0, 15));
            if (choice == 0) begin
                repeat ($urandom_range(1, 8)) emit(4'($urandom_range(0, 15)));
            end else if (choice == 1) begin
                repeat ($urandom_range(1, cur_rounds * 16)) emit(key_lines(key));
                repeat ($urandom_range(1, 20)) emit(4'hf);
            end else begin
                hold = cur_rounds * 16 + 16 + $urandom_range(0, 24);
                repeat (hold) begin
                    emit(($urandom_range(0, 24) == 0) ? 4'($urandom_range(0, 15))
                                                      : key_lines(key));
                end
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, cur_release)) emit(4'hf);
                    repeat ($urandom_range(1, 20)) emit(key_lines(key));
                end
                repeat (cur_release + $urandom_range(1, 8)) emit(4'hf);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_return_lines <= 4'hf;
        i_cfg_we <= 1'b0;
        i_cfg_index <= kpsd_pkg::CFG_DEBOUNCE_ROUNDS;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int v = 0; v < 16; v++) begin
            send_tick(4'(v));
        end
        send_tick(4'hf);
        send_tick(4'h0);

        run_ticks(300);
        reconfigure(4'd1, 8'd1);
        run_ticks(300);
        reconfigure(4'd0, 8'd0);
        run_ticks(250);
        reconfigure(4'd15, 8'd255);
        run_ticks(550);
        reconfigure(4'd3, 8'd5);
        run_ticks(250);
        reconfigure(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        run_ticks(250);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
